/* rtl/core/coherent_flow_motion_check_defines.svh */
// Assertion macros of the port-level checker of the coherent flow motion check.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef COHERENT_FLOW_MOTION_CHECK_DEFINES_SVH
`define COHERENT_FLOW_MOTION_CHECK_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CFMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfmc check failed");

// Next-cycle implication, checked outside reset
`define CFMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfmc check failed");

`endif

/* rtl/core/cfmc_pkg.sv */
// Package of the coherent flow motion check: sizes, register indexes, reset values,
// multiplier request/response types and small helper functions. No dependencies.
package cfmc_pkg;

    localparam int MAX_VECTORS = 16384;
    localparam int ADDR_W      = $clog2(MAX_VECTORS);
    localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
    localparam int MUL_A_W     = 128;
    localparam int MUL_B_W     = 64;
    localparam int CFG_W       = 17;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_MIN_MAGNITUDE = 2'd0;
    localparam logic [IDX_W-1:0] REG_COS_TOLERANCE = 2'd1;
    localparam logic [IDX_W-1:0] REG_MOTION_RATIO  = 2'd2;

    localparam logic [15:0] MIN_MAGNITUDE_RST = 16'd64;
    localparam logic [15:0] COS_TOLERANCE_RST = 16'd30784;
    localparam logic [16:0] MOTION_RATIO_RST  = 17'd32768;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MUL_A_W-1:0] p;
    } mul_rsp_t;

    // magnitude of a 16-bit signed value
    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : e;
    endfunction

    // magnitude of a 32-bit signed value
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // magnitude of a 48-bit signed value
    function automatic logic [47:0] abs48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

endpackage

/* rtl/core/cfmc_mul.sv */
// Shared shift-add multiplier of the coherent flow motion check, one bit per cycle.
// Depends on cfmc_pkg for the request and response types.
module cfmc_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  cfmc_pkg::mul_req_t req,
    output cfmc_pkg::mul_rsp_t rsp
);

    logic                        run_reg;
    logic [cfmc_pkg::MUL_A_W-1:0] a_reg;
    logic [cfmc_pkg::MUL_B_W-1:0] b_reg;
    logic [cfmc_pkg::MUL_A_W-1:0] acc_reg;

    // Finish as soon as no multiplier bits remain
    assign rsp.busy = run_reg;
    assign rsp.done = run_reg && (b_reg == '0);
    assign rsp.p    = acc_reg;

    // Load operands, then add and shift until the multiplier is exhausted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (req.start && !run_reg)
        begin
            run_reg <= 1'b1;
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (b_reg == '0)
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= a_reg << 1;
                b_reg <= b_reg >> 1;
            end
        end
    end

endmodule

/* rtl/core/cfmc_store.sv */
// Vector store of the coherent flow motion check: one write and one registered read.
// Depends on cfmc_pkg for depth and address width.
module cfmc_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [cfmc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [31:0]                 wr_data,
    input  logic [cfmc_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]                 rd_data
);

    logic [31:0] mem [cfmc_pkg::MAX_VECTORS];
    logic [31:0] rd_data_reg;

    // Write the incoming vector
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/coherent_flow_motion_check.sv */
// Coherent flow motion check: each vector on load runs through the shared
// one-bit-per-cycle multiplier, whose run length the operand bits decide.
// The last vector adds the decision: with moving vectors and a long enough mean
// vector, a second pass over every stored vector and then the ratio test.
// One vector at a time; the next waits for its work and any result transfer.
// rst_n clears region state and loads register defaults; the store is not cleared.
module coherent_flow_motion_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] flow_dx,
    input  logic signed [15:0] flow_dy,
    input  logic               last_vector,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               has_motion,
    output logic               overflow,
    output logic [14:0]        aligned_count
);

    typedef enum logic [4:0] {
        S_IDLE, S_MIN2, S_SQX, S_SQY, S_END, S_SX, S_SY, S_MC2, S_NEED,
        S_C2, S_K, S_RD, S_RDW, S_DX, S_DY, S_AD2, S_KV, S_RATIO, S_RESULT
    } state_t;

    state_t                             state_reg;
    logic [15:0]                        min_mag_reg;
    logic signed [15:0]                 cos_tol_reg;
    logic [16:0]                        ratio_reg;
    logic signed [31:0]                 sum_x_reg;
    logic signed [31:0]                 sum_y_reg;
    logic [cfmc_pkg::CNT_W-1:0]         moving_reg;
    logic [cfmc_pkg::CNT_W-1:0]         total_reg;
    logic [cfmc_pkg::CNT_W-1:0]         idx_reg;
    logic [14:0]                        aligned_reg;
    logic                               ovf_reg;
    logic                               motion_reg;
    logic                               last_reg;
    logic                               stored_reg;
    logic                               pass_reg;
    logic signed [15:0]                 vx_reg;
    logic signed [15:0]                 vy_reg;
    logic [63:0]                        t0_reg;
    logic [31:0]                        min2_reg;
    logic [63:0]                        smag2_reg;
    logic [31:0]                        c2_reg;
    logic [95:0]                        k_reg;
    logic [32:0]                        vm2_reg;
    logic signed [47:0]                 dot_reg;
    logic [95:0]                        ad2_reg;

    cfmc_pkg::mul_req_t                 mul_req;
    cfmc_pkg::mul_rsp_t                 mul_rsp;
    logic                               wr_en;
    logic [31:0]                        rd_data;
    logic                               accept;
    logic                               has_room;
    logic                               is_mul;
    logic [32:0]                        vm2_sum;
    logic signed [47:0]                 term;
    logic signed [47:0]                 dot_sum;
    logic [cfmc_pkg::MUL_A_W-1:0]       lhs;
    logic                               lhs_ge;
    logic                               lhs_le;

    assign in_stall      = (state_reg != S_IDLE);
    assign accept        = in_valid && !in_stall;
    assign has_room      = (total_reg < cfmc_pkg::CNT_W'(cfmc_pkg::MAX_VECTORS));
    assign wr_en         = accept && has_room;
    assign out_valid     = (state_reg == S_RESULT);
    assign has_motion    = motion_reg;
    assign overflow      = ovf_reg;
    assign aligned_count = aligned_reg;

    cfmc_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[cfmc_pkg::ADDR_W-1:0]),
        .wr_data ({flow_dy, flow_dx}),
        .rd_addr (idx_reg[cfmc_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    cfmc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Select multiplier operands for the current step
    always_comb
    begin
        is_mul    = 1'b1;
        mul_req.a = '0;
        mul_req.b = '0;
        case (state_reg)
            S_MIN2:
            begin
                mul_req.a = 128'(min_mag_reg);
                mul_req.b = 64'(min_mag_reg);
            end
            S_SQX:
            begin
                mul_req.a = 128'(cfmc_pkg::abs16(vx_reg));
                mul_req.b = 64'(cfmc_pkg::abs16(vx_reg));
            end
            S_SQY:
            begin
                mul_req.a = 128'(cfmc_pkg::abs16(vy_reg));
                mul_req.b = 64'(cfmc_pkg::abs16(vy_reg));
            end
            S_SX:
            begin
                mul_req.a = 128'(cfmc_pkg::abs32(sum_x_reg));
                mul_req.b = 64'(cfmc_pkg::abs32(sum_x_reg));
            end
            S_SY:
            begin
                mul_req.a = 128'(cfmc_pkg::abs32(sum_y_reg));
                mul_req.b = 64'(cfmc_pkg::abs32(sum_y_reg));
            end
            S_MC2:
            begin
                mul_req.a = 128'(moving_reg);
                mul_req.b = 64'(moving_reg);
            end
            S_NEED:
            begin
                mul_req.a = 128'(t0_reg);
                mul_req.b = 64'(min2_reg);
            end
            S_C2:
            begin
                mul_req.a = 128'(cfmc_pkg::abs16(cos_tol_reg));
                mul_req.b = 64'(cfmc_pkg::abs16(cos_tol_reg));
            end
            S_K:
            begin
                mul_req.a = 128'(smag2_reg);
                mul_req.b = 64'(c2_reg);
            end
            S_DX:
            begin
                mul_req.a = 128'(cfmc_pkg::abs32(sum_x_reg));
                mul_req.b = 64'(cfmc_pkg::abs16(vx_reg));
            end
            S_DY:
            begin
                mul_req.a = 128'(cfmc_pkg::abs32(sum_y_reg));
                mul_req.b = 64'(cfmc_pkg::abs16(vy_reg));
            end
            S_AD2:
            begin
                mul_req.a = 128'(cfmc_pkg::abs48(dot_reg));
                mul_req.b = 64'(cfmc_pkg::abs48(dot_reg));
            end
            S_KV:
            begin
                mul_req.a = 128'(k_reg);
                mul_req.b = 64'(vm2_reg);
            end
            S_RATIO:
            begin
                mul_req.a = 128'(total_reg);
                mul_req.b = 64'(ratio_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_req.start = is_mul && !mul_rsp.busy;
    end

    // Combine partial results: squared length, signed dot term, alignment compares
    always_comb
    begin
        vm2_sum = 33'(t0_reg) + 33'(mul_rsp.p);
        if (state_reg == S_DX)
        begin
            term = (vx_reg[15] ^ sum_x_reg[31]) ? -$signed(mul_rsp.p[47:0])
                                                : $signed(mul_rsp.p[47:0]);
        end
        else
        begin
            term = (vy_reg[15] ^ sum_y_reg[31]) ? -$signed(mul_rsp.p[47:0])
                                                : $signed(mul_rsp.p[47:0]);
        end
        dot_sum = dot_reg + term;
        lhs     = {2'b00, ad2_reg, 30'b0};
        lhs_ge  = (lhs >= mul_rsp.p);
        lhs_le  = (lhs <= mul_rsp.p);
    end

    // Sequencer: configuration, loading, decision and second pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            min_mag_reg <= cfmc_pkg::MIN_MAGNITUDE_RST;
            cos_tol_reg <= cfmc_pkg::COS_TOLERANCE_RST;
            ratio_reg   <= cfmc_pkg::MOTION_RATIO_RST;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            moving_reg  <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            aligned_reg <= '0;
            ovf_reg     <= 1'b0;
            motion_reg  <= 1'b0;
            last_reg    <= 1'b0;
            stored_reg  <= 1'b0;
            pass_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cfmc_pkg::REG_MIN_MAGNITUDE: min_mag_reg <= cfg_data[15:0];
                    cfmc_pkg::REG_COS_TOLERANCE: cos_tol_reg <= $signed(cfg_data[15:0]);
                    cfmc_pkg::REG_MOTION_RATIO:  ratio_reg   <= cfg_data;
                    default:                     ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        vx_reg     <= flow_dx;
                        vy_reg     <= flow_dy;
                        last_reg   <= last_vector;
                        stored_reg <= has_room;
                        pass_reg   <= 1'b0;
                        if (has_room)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= S_MIN2;
                    end
                end
                S_MIN2:
                begin
                    if (mul_rsp.done)
                    begin
                        min2_reg  <= mul_rsp.p[31:0];
                        state_reg <= stored_reg ? S_SQX : S_END;
                    end
                end
                S_SQX:
                begin
                    if (mul_rsp.done)
                    begin
                        t0_reg    <= mul_rsp.p[63:0];
                        state_reg <= S_SQY;
                    end
                end
                S_SQY:
                begin
                    if (mul_rsp.done)
                    begin
                        vm2_reg <= vm2_sum;
                        if (!pass_reg)
                        begin
                            // count a moving vector into the sums
                            if (vm2_sum >= 33'(min2_reg))
                            begin
                                sum_x_reg  <= sum_x_reg + 32'(vx_reg);
                                sum_y_reg  <= sum_y_reg + 32'(vy_reg);
                                moving_reg <= moving_reg + 1'b1;
                            end
                            state_reg <= S_END;
                        end
                        else if (vm2_sum < 33'(min2_reg))
                        begin
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            dot_reg   <= '0;
                            state_reg <= S_DX;
                        end
                    end
                end
                S_END:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (moving_reg == '0)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_SX;
                    end
                end
                S_SX:
                begin
                    if (mul_rsp.done)
                    begin
                        t0_reg    <= mul_rsp.p[63:0];
                        state_reg <= S_SY;
                    end
                end
                S_SY:
                begin
                    if (mul_rsp.done)
                    begin
                        smag2_reg <= t0_reg + mul_rsp.p[63:0];
                        state_reg <= S_MC2;
                    end
                end
                S_MC2:
                begin
                    if (mul_rsp.done)
                    begin
                        t0_reg    <= mul_rsp.p[63:0];
                        state_reg <= S_NEED;
                    end
                end
                S_NEED:
                begin
                    // drop to no motion when the mean vector is too short
                    if (mul_rsp.done)
                    begin
                        state_reg <= (128'(smag2_reg) >= mul_rsp.p) ? S_C2 : S_RESULT;
                    end
                end
                S_C2:
                begin
                    if (mul_rsp.done)
                    begin
                        c2_reg    <= mul_rsp.p[31:0];
                        state_reg <= S_K;
                    end
                end
                S_K:
                begin
                    if (mul_rsp.done)
                    begin
                        k_reg     <= mul_rsp.p[95:0];
                        idx_reg   <= '0;
                        pass_reg  <= 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= (idx_reg == total_reg) ? S_RATIO : S_RDW;
                end
                S_RDW:
                begin
                    vx_reg    <= $signed(rd_data[15:0]);
                    vy_reg    <= $signed(rd_data[31:16]);
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SQX;
                end
                S_DX:
                begin
                    if (mul_rsp.done)
                    begin
                        dot_reg   <= dot_sum;
                        state_reg <= S_DY;
                    end
                end
                S_DY:
                begin
                    if (mul_rsp.done)
                    begin
                        dot_reg   <= dot_sum;
                        state_reg <= S_AD2;
                    end
                end
                S_AD2:
                begin
                    if (mul_rsp.done)
                    begin
                        ad2_reg   <= mul_rsp.p[95:0];
                        state_reg <= S_KV;
                    end
                end
                S_KV:
                begin
                    // compare squared dot against squared cosine bound
                    if (mul_rsp.done)
                    begin
                        if (!cos_tol_reg[15])
                        begin
                            if (!dot_reg[47] && lhs_ge)
                            begin
                                aligned_reg <= aligned_reg + 1'b1;
                            end
                        end
                        else if (!dot_reg[47] || lhs_le)
                        begin
                            aligned_reg <= aligned_reg + 1'b1;
                        end
                        state_reg <= S_RD;
                    end
                end
                S_RATIO:
                begin
                    if (mul_rsp.done)
                    begin
                        motion_reg <= ({aligned_reg, 16'b0} >= mul_rsp.p[30:0])
                                      && (mul_rsp.p[127:31] == '0);
                        state_reg  <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    // hold the result until its transfer, then clear the region
                    if (!out_stall)
                    begin
                        sum_x_reg   <= '0;
                        sum_y_reg   <= '0;
                        moving_reg  <= '0;
                        total_reg   <= '0;
                        aligned_reg <= '0;
                        ovf_reg     <= 1'b0;
                        motion_reg  <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/cfmc_checker.sv */
// Port-level checker of the coherent flow motion check, bound to the top level.
// Depends on coherent_flow_motion_check_defines.svh for the assertion macros.
`include "coherent_flow_motion_check_defines.svh"

module cfmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        has_motion,
    input logic        overflow,
    input logic [14:0] aligned_count
);

    // a waiting result keeps the input side closed
    `CFMC_ASSERT_NOW(a_result_blocks_input, out_valid, in_stall)
    // an input transfer always starts work that keeps the input side closed with no result offered
    `CFMC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall && !out_valid)
    // a stalled result stays offered
    `CFMC_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid)
    // a stalled result keeps its fields
    `CFMC_ASSERT_NEXT(a_fields_hold, out_valid && out_stall,
        $stable(has_motion) && $stable(overflow) && $stable(aligned_count))

endmodule

bind coherent_flow_motion_check cfmc_checker u_cfmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .has_motion    (has_motion),
    .overflow      (overflow),
    .aligned_count (aligned_count)
);

/* tb/testbench.sv */
// Testbench of the coherent flow motion check: random and directed flow regions with
// a built-in predictor of the decision and a scoreboard of the expected results.
// Depends on cfmc_pkg and the coherent_flow_motion_check top level.
`timescale 1ns / 1ps

module testbench;

    localparam logic [cfmc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam int RAND_ITEMS = 400;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               last;
    } flow_vec_t;

    typedef struct {
        logic        motion;
        logic        ovf;
        logic [14:0] count;
    } verdict_t;

    typedef enum int {REGION_COHERENT, REGION_NOISE, REGION_STILL, REGION_MIXED} region_kind_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] flow_dx;
    logic signed [15:0] flow_dy;
    logic               last_vector;
    logic               out_valid;
    logic               out_stall;
    logic               has_motion;
    logic               overflow;
    logic [14:0]        aligned_count;

    coherent_flow_motion_check DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .flow_dx(flow_dx), .flow_dy(flow_dy), .last_vector(last_vector),
        .out_valid(out_valid), .out_stall(out_stall),
        .has_motion(has_motion), .overflow(overflow), .aligned_count(aligned_count)
    );

    // stimulus and scoreboard
    flow_vec_t pending_vecs[$];
    verdict_t  expected_verdicts[$];
    int        fail_count;
    longint    cycle_count;
    logic      took_vec;

    // register shadow
    logic [15:0]        min_mag_reg;
    logic signed [15:0] cos_tol_reg;
    logic [16:0]        ratio_reg;

    // region shadow
    logic signed [15:0] region_dx[$];
    logic signed [15:0] region_dy[$];
    longint             region_sum_x;
    longint             region_sum_y;
    int                 region_moving;
    logic               region_dropped;

    // sender and receiver pacing
    int   burst_left;
    int   gap_left;
    logic send_pause;
    int   stall_mode;
    int   mode_left;
    int   hold_cnt;
    logic hold_req;
    logic hold_used;

    function automatic logic [63:0] vec_mag2(longint x, longint y);
        return 64'(x * x + y * y);
    endfunction

    // count moving vectors within the angle tolerance of the summed direction
    function automatic int count_aligned_vectors();
        logic [255:0] smag2, lhs, rhs;
        logic [63:0]  c2, min2, vm2, ad;
        longint       dot, x, y;
        int           n;
        n = 0;
        smag2 = 256'(vec_mag2(region_sum_x, region_sum_y));
        c2 = 64'(longint'(cos_tol_reg) * longint'(cos_tol_reg));
        min2 = 64'(min_mag_reg) * 64'(min_mag_reg);
        for (int i = 0; i < region_dx.size(); i++)
        begin
            x = region_dx[i];
            y = region_dy[i];
            vm2 = vec_mag2(x, y);
            if (vm2 < min2)
                continue;
            dot = x * region_sum_x + y * region_sum_y;
            ad = (dot < 0) ? 64'(-dot) : 64'(dot);
            lhs = (256'(ad) * 256'(ad)) << 30;
            rhs = 256'(c2) * 256'(vm2) * smag2;
            if (cos_tol_reg >= 0)
            begin
                if (dot >= 0 && lhs >= rhs)
                    n++;
            end
            else if (dot >= 0 || lhs <= rhs)
                n++;
        end
        return n;
    endfunction

    // advance the region shadow by one transfer; queue a verdict on the last vector
    function automatic void predict_motion(flow_vec_t v);
        logic [63:0]  min2;
        logic [255:0] smag2, need;
        verdict_t     vd;
        int           n;
        min2 = 64'(min_mag_reg) * 64'(min_mag_reg);
        if (region_dx.size() < cfmc_pkg::MAX_VECTORS)
        begin
            region_dx = {region_dx, v.dx};
            region_dy = {region_dy, v.dy};
            if (vec_mag2(v.dx, v.dy) >= min2)
            begin
                region_sum_x += v.dx;
                region_sum_y += v.dy;
                region_moving++;
            end
        end
        else
            region_dropped = 1'b1;
        if (!v.last)
            return;
        n = 0;
        vd.motion = 1'b0;
        if (region_moving != 0)
        begin
            smag2 = 256'(vec_mag2(region_sum_x, region_sum_y));
            need = 256'(min2) * 256'(region_moving) * 256'(region_moving);
            if (smag2 >= need)
            begin
                n = count_aligned_vectors();
                vd.motion = (64'(n) << 16) >= 64'(region_dx.size()) * 64'(ratio_reg);
            end
        end
        vd.ovf = region_dropped;
        vd.count = 15'(n);
        expected_verdicts = {expected_verdicts, vd};
        region_dx.delete();
        region_dy.delete();
        region_sum_x = 0;
        region_sum_y = 0;
        region_moving = 0;
        region_dropped = 1'b0;
    endfunction

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic void queue_vec(int x, int y, logic last);
        flow_vec_t v;
        v.dx = clip16(x);
        v.dy = clip16(y);
        v.last = last;
        pending_vecs = {pending_vecs, v};
    endfunction

    // build one region of n vectors of the given character
    function automatic int queue_region(int n, region_kind_t kind);
        int bx, by, sp, x, y;
        bx = $urandom_range(8000) - 4000;
        by = $urandom_range(8000) - 4000;
        sp = $urandom_range(1500);
        for (int i = 0; i < n; i++)
        begin
            x = $urandom_range(65535) - 32768;
            y = $urandom_range(65535) - 32768;
            case (kind)
                REGION_COHERENT:
                begin
                    x = bx + $urandom_range(2 * sp) - sp;
                    y = by + $urandom_range(2 * sp) - sp;
                end
                REGION_STILL:
                begin
                    x = $urandom_range(100) - 50;
                    y = $urandom_range(100) - 50;
                end
                REGION_MIXED:
                    if ($urandom_range(2) != 0)
                    begin
                        x = bx + $urandom_range(2 * sp) - sp;
                        y = by + $urandom_range(2 * sp) - sp;
                    end
                default: ;
            endcase
            queue_vec(x, y, i == n - 1);
        end
        return n;
    endfunction

    // random regions, half of them coherent, until about n vectors are queued
    function automatic void queue_random_regions(int n);
        int done, k;
        region_kind_t kind;
        done = 0;
        while (done < n)
        begin
            k = $urandom_range(9);
            kind = (k < 5) ? REGION_COHERENT : (k < 7) ? REGION_MIXED :
                   (k < 8) ? REGION_STILL : REGION_NOISE;
            done += queue_region($urandom_range(12, 1), kind);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            cfmc_pkg::REG_MIN_MAGNITUDE: min_mag_reg = val[15:0];
            cfmc_pkg::REG_COS_TOLERANCE: cos_tol_reg = val[15:0];
            cfmc_pkg::REG_MOTION_RATIO:  ratio_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every queued vector is taken and every verdict has arrived
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_vecs.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sender: bursts of transfers with random gaps
    always @(negedge clk)
    begin
        if (!(in_valid && !took_vec))
        begin
            if (gap_left > 0 || send_pause || pending_vecs.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                flow_dx <= pending_vecs[0].dx;
                flow_dy <= pending_vecs[0].dy;
                last_vector <= pending_vecs[0].last;
                void'(pending_vecs.pop_front());
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(20);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_cnt <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(2);
                mode_left <= $urandom_range(200, 10);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(1) == 0);
                default: out_stall <= ($urandom_range(7) != 0);
            endcase
        end
    end

    // monitor: predict on input transfers, check on result transfers
    always @(posedge clk)
    begin
        flow_vec_t v;
        verdict_t  e;
        took_vec <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            v.dx = flow_dx;
            v.dy = flow_dy;
            v.last = last_vector;
            predict_motion(v);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result motion=%0b overflow=%0b aligned=%0d",
                         $time, has_motion, overflow, aligned_count);
                fail_count++;
            end
            else
            begin
                e = expected_verdicts.pop_front();
                if (has_motion !== e.motion)
                begin
                    $display("%0t: has_motion expected %0b actual %0b",
                             $time, e.motion, has_motion);
                    fail_count++;
                end
                if (overflow !== e.ovf)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow);
                    fail_count++;
                end
                if (aligned_count !== e.count)
                begin
                    $display("%0t: aligned_count expected %0d actual %0d",
                             $time, e.count, aligned_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = cfmc_pkg::REG_MIN_MAGNITUDE;
        cfg_data = '0;
        in_valid = 1'b0;
        flow_dx = '0;
        flow_dy = '0;
        last_vector = 1'b0;
        out_stall = 1'b0;
        took_vec = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        send_pause = 1'b0;
        stall_mode = 0;
        mode_left = 0;
        hold_cnt = 0;
        hold_req = 1'b0;
        hold_used = 1'b0;
        min_mag_reg = cfmc_pkg::MIN_MAGNITUDE_RST;
        cos_tol_reg = cfmc_pkg::COS_TOLERANCE_RST;
        ratio_reg = cfmc_pkg::MOTION_RATIO_RST;
        region_sum_x = 0;
        region_sum_y = 0;
        region_moving = 0;
        region_dropped = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, single vectors, still region, cancelling pair
        queue_vec(32767, 32767, 1'b1);
        queue_vec(-32768, -32768, 1'b1);
        queue_vec(0, 0, 1'b1);
        queue_vec(32767, -32768, 1'b0);
        queue_vec(-32768, 32767, 1'b1);
        queue_vec(1000, 0, 1'b0);
        queue_vec(-1000, 0, 1'b1);
        queue_vec(10, -10, 1'b0);
        queue_vec(-20, 5, 1'b1);
        queue_vec(2000, 2000, 1'b0);
        queue_vec(2100, 1900, 1'b0);
        queue_vec(-2000, 2000, 1'b0);
        queue_vec(30, 0, 1'b1);
        queue_vec(-1, -1, 1'b0);
        queue_vec(64, 0, 1'b0);
        queue_vec(63, 0, 1'b1);
        wait_drained();

        // register sweep, extremes included; index past the list is ignored
        write_reg(REG_UNUSED, 17'h1FFFF);
        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'd0);
                1: write_reg(cfmc_pkg::REG_COS_TOLERANCE, 17'h08000);
                2: write_reg(cfmc_pkg::REG_MOTION_RATIO, 17'd65536);
                3: write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'd65535);
                4: write_reg(cfmc_pkg::REG_COS_TOLERANCE, 17'h07FFF);
                5: write_reg(cfmc_pkg::REG_MOTION_RATIO, 17'd0);
                6: write_reg(cfmc_pkg::REG_COS_TOLERANCE, 17'd0);
                7:
                begin
                    write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'($urandom_range(2000)));
                    write_reg(cfmc_pkg::REG_COS_TOLERANCE, 17'($urandom_range(65535)));
                end
                default:
                begin
                    write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'(cfmc_pkg::MIN_MAGNITUDE_RST));
                    write_reg(cfmc_pkg::REG_COS_TOLERANCE, 17'(cfmc_pkg::COS_TOLERANCE_RST));
                    write_reg(cfmc_pkg::REG_MOTION_RATIO, 17'($urandom_range(65536)));
                end
            endcase
            if (p == 3)
                write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'($urandom_range(300, 40)));
            queue_random_regions(RAND_ITEMS / 9);
            if (p == 4)
                hold_req = 1'b1;
            wait_drained();
        end

        // capacity: fill the store with still vectors, then drop two more
        write_reg(cfmc_pkg::REG_MIN_MAGNITUDE, 17'(cfmc_pkg::MIN_MAGNITUDE_RST));
        for (int i = 0; i < cfmc_pkg::MAX_VECTORS + 2; i++)
            queue_vec(0, ($urandom_range(1) == 0) ? 1 : -1, i == cfmc_pkg::MAX_VECTORS + 1);
        queue_random_regions(20);
        wait_drained();

        repeat (1000) @(posedge clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
